// File: hdl/rrbe_pkg.sv
package rrbe_pkg;

	localparam int unsigned POS_W   = 18;
	localparam int unsigned WORDS_W = 16;
	localparam int unsigned EXP_W   = 6;
	localparam int unsigned MANT_W  = 18;
	localparam int unsigned RATE_W  = 32;

	localparam logic [1:0] RTCP_VERSION = 2'd2;
	localparam logic [4:0] FMT_REMB     = 5'd15;
	localparam logic [7:0] TYPE_PSFB    = 8'd206;
	localparam logic [7:0] CHAR_R       = 8'h52;
	localparam logic [7:0] CHAR_E       = 8'h45;
	localparam logic [7:0] CHAR_M       = 8'h4D;
	localparam logic [7:0] CHAR_B       = 8'h42;
	localparam logic [WORDS_W-1:0] MIN_REMB_WORDS = 16'd4;

	// Byte offsets inside a sub-packet
	localparam logic [POS_W-1:0] POS_HDR    = 18'd0;
	localparam logic [POS_W-1:0] POS_TYPE   = 18'd1;
	localparam logic [POS_W-1:0] POS_LEN_HI = 18'd2;
	localparam logic [POS_W-1:0] POS_LEN_LO = 18'd3;
	localparam logic [POS_W-1:0] POS_ID0    = 18'd12;
	localparam logic [POS_W-1:0] POS_ID1    = 18'd13;
	localparam logic [POS_W-1:0] POS_ID2    = 18'd14;
	localparam logic [POS_W-1:0] POS_ID3    = 18'd15;
	localparam logic [POS_W-1:0] POS_BR0    = 18'd17;
	localparam logic [POS_W-1:0] POS_BR1    = 18'd18;
	localparam logic [POS_W-1:0] POS_BR2    = 18'd19;

	typedef struct packed {
		logic              done;
		logic [EXP_W-1:0]  exponent;
		logic [MANT_W-1:0] mantissa;
	} walk_t;

endpackage

// File: hdl/rrbe_walk.sv
module rrbe_walk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output rrbe_pkg::walk_t     walk
);

	logic [rrbe_pkg::POS_W-1:0]   pos_q, pos_n;
	logic [rrbe_pkg::WORDS_W-1:0] words_q, words_n;
	logic                         first_q, first_n;
	logic                         stop_q, stop_n;
	logic                         cand_q, cand_n;
	logic [rrbe_pkg::EXP_W-1:0]   exp_q, exp_n;
	logic [rrbe_pkg::MANT_W-1:0]  mant_q, mant_n;
	logic                         done_q, done_n;
	logic                         adv;
	logic [rrbe_pkg::POS_W:0]     pos_inc;
	logic [rrbe_pkg::POS_W:0]     sub_end;

	always_comb begin
		pos_n   = pos_q;
		words_n = words_q;
		first_n = first_q;
		stop_n  = stop_q;
		cand_n  = cand_q;
		exp_n   = exp_q;
		mant_n  = mant_q;
		done_n  = done_q;
		adv     = 1'b0;
		pos_inc = {1'b0, pos_q} + 19'd1;
		sub_end = 19'd0;
		if (!stop_q && !done_q) begin
			adv = 1'b1;
			case (pos_q)
				rrbe_pkg::POS_HDR: begin
					if (first_q && data_byte[7:6] != rrbe_pkg::RTCP_VERSION) begin
						stop_n = 1'b1;
						adv    = 1'b0;
					end else begin
						cand_n = (data_byte[4:0] == rrbe_pkg::FMT_REMB);
					end
				end
				rrbe_pkg::POS_TYPE:   cand_n = cand_q && (data_byte == rrbe_pkg::TYPE_PSFB);
				rrbe_pkg::POS_LEN_HI: words_n = {data_byte, 8'h00};
				rrbe_pkg::POS_LEN_LO: begin
					words_n = {words_q[15:8], data_byte};
					if (words_n < rrbe_pkg::MIN_REMB_WORDS)
						cand_n = 1'b0;
					if (words_n == '0) begin
						stop_n = 1'b1;
						adv    = 1'b0;
					end
				end
				rrbe_pkg::POS_ID0: cand_n = cand_q && (data_byte == rrbe_pkg::CHAR_R);
				rrbe_pkg::POS_ID1: cand_n = cand_q && (data_byte == rrbe_pkg::CHAR_E);
				rrbe_pkg::POS_ID2: cand_n = cand_q && (data_byte == rrbe_pkg::CHAR_M);
				rrbe_pkg::POS_ID3: cand_n = cand_q && (data_byte == rrbe_pkg::CHAR_B);
				rrbe_pkg::POS_BR0: begin
					exp_n  = data_byte[7:2];
					mant_n = {data_byte[1:0], 16'h0000};
				end
				rrbe_pkg::POS_BR1: mant_n = mant_q | {2'b00, data_byte, 8'h00};
				rrbe_pkg::POS_BR2: begin
					mant_n = mant_q | {10'd0, data_byte};
					if (cand_q) begin
						done_n = 1'b1;
						adv    = 1'b0;
					end
				end
				default: ;
			endcase
			if (adv) begin
				// sub-packet spans (length + 1) words
				sub_end = {1'b0, words_n, 2'b00} + 19'd4;
				if (pos_q >= rrbe_pkg::POS_LEN_LO && pos_inc == sub_end) begin
					pos_n   = '0;
					first_n = 1'b0;
					cand_n  = 1'b0;
				end else begin
					pos_n = pos_inc[rrbe_pkg::POS_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			words_q <= '0;
			first_q <= 1'b1;
			stop_q  <= 1'b0;
			cand_q  <= 1'b0;
			exp_q   <= '0;
			mant_q  <= '0;
			done_q  <= 1'b0;
		end else if (en) begin
			if (last_byte) begin
				// packet ends: back to the start state
				pos_q   <= '0;
				words_q <= '0;
				first_q <= 1'b1;
				stop_q  <= 1'b0;
				cand_q  <= 1'b0;
				exp_q   <= '0;
				mant_q  <= '0;
				done_q  <= 1'b0;
			end else begin
				pos_q   <= pos_n;
				words_q <= words_n;
				first_q <= first_n;
				stop_q  <= stop_n;
				cand_q  <= cand_n;
				exp_q   <= exp_n;
				mant_q  <= mant_n;
				done_q  <= done_n;
			end
		end
	end

	assign walk.done     = done_n;
	assign walk.exponent = exp_n;
	assign walk.mantissa = mant_n;

endmodule

// File: hdl/rrbe_scale.sv
module rrbe_scale (
	input  rrbe_pkg::walk_t                walk,
	output logic                           found,
	output logic [rrbe_pkg::RATE_W-1:0]    value,
	output logic                           overflow
);

	localparam int unsigned SHIFT_W = rrbe_pkg::RATE_W + rrbe_pkg::MANT_W;

	logic [SHIFT_W-1:0] shifted;
	logic               sat;

	always_comb begin
		shifted = SHIFT_W'(walk.mantissa) << walk.exponent;
		// exponent of 32 or more always spills past 32 bits for a nonzero mantissa
		sat = (walk.mantissa != '0) &&
			(walk.exponent[rrbe_pkg::EXP_W-1] || (shifted[SHIFT_W-1:rrbe_pkg::RATE_W] != '0));
		found    = walk.done;
		overflow = walk.done && sat;
		if (!walk.done)
			value = '0;
		else if (sat)
			value = '1;
		else
			value = shifted[rrbe_pkg::RATE_W-1:0];
	end

endmodule

// File: hdl/rtcp_remb_bitrate_extract.sv
// A last byte's result is computed from the input register and registered in the result
// register once that has room. Throughput: one byte per cycle unless a last byte
// waits on a full, stalled result; these two registers are the only stages.
// Reset: arst_n clears all control state asynchronously; the walk state also returns
// to its start values after each packet's last byte.
module rtcp_remb_bitrate_extract (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   data_byte,
	input  logic                         last_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         remb_found,
	output logic [rrbe_pkg::RATE_W-1:0]  bitrate_value,
	output logic                         bitrate_overflow
);

	logic                         valid_s1;
	logic [7:0]                   data_s1;
	logic                         last_s1;
	logic                         go;
	logic                         out_valid_q;
	rrbe_pkg::walk_t              walk;
	logic                         found_c;
	logic [rrbe_pkg::RATE_W-1:0]  value_c;
	logic                         ovf_c;

	// only a last byte needs room in the result register
	assign go       = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	rrbe_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (go),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.walk      (walk)
	);

	rrbe_scale u_scale (
		.walk     (walk),
		.found    (found_c),
		.value    (value_c),
		.overflow (ovf_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			remb_found       <= found_c;
			bitrate_value    <= value_c;
			bitrate_overflow <= ovf_c;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && last_s1))
		else $error("input stalled without a blocked result");

	a_ovf_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bitrate_overflow) |-> (remb_found && bitrate_value == '1))
		else $error("overflow without saturated bitrate");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !remb_found) |-> (bitrate_value == '0 && !bitrate_overflow))
		else $error("result fields set without a match");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		(go && last_s1) |=> out_valid)
		else $error("last byte produced no result");
`endif

endmodule

// File: tb/sv/rtcp_remb_bitrate_extract_tb.sv
`timescale 1ns / 1ps

module rtcp_remb_bitrate_extract_tb;
	import rrbe_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned RANDOM_BYTES = 1750;
	localparam int unsigned CALM_TAIL    = 300;
	localparam int unsigned HOLD_AT      = 600;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_AT     = 900;
	localparam int unsigned NO_CAP       = 32'hFFFF_FFFF;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       drain;
	} byte_item_t;

	typedef struct {
		logic                found;
		logic [RATE_W-1:0]   rate;
		logic                ovf;
	} bitrate_report_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic [7:0]         data_byte = 8'h00;
	logic               last_byte = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               remb_found;
	logic [RATE_W-1:0]  bitrate_value;
	logic               bitrate_overflow;

	rtcp_remb_bitrate_extract dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.data_byte        (data_byte),
		.last_byte        (last_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.remb_found       (remb_found),
		.bitrate_value    (bitrate_value),
		.bitrate_overflow (bitrate_overflow)
	);

	// packet walk state of the predictor
	logic [POS_W-1:0]   walk_pos;
	logic [WORDS_W-1:0] walk_words;
	logic               walk_first;
	logic               walk_stopped;
	logic               walk_cand;
	logic [EXP_W-1:0]   walk_exp;
	logic [MANT_W-1:0]  walk_mant;
	logic               walk_matched;

	byte_item_t       tx_bytes_q[$];
	bitrate_report_t  bitrate_reports_q[$];
	logic [7:0]       pkt[$];

	int unsigned total_bytes   = 0;
	int unsigned taken_bytes   = 0;
	int unsigned cycle_count   = 0;
	int unsigned err_count     = 0;
	int unsigned gap_left      = 0;
	int unsigned stall_left    = 0;
	int unsigned hold_left     = 0;
	logic        hold_done     = 1'b0;
	logic        in_took       = 1'b0;
	logic        idle_ok       = 1'b0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic walk_clear();
		walk_pos     = '0;
		walk_words   = '0;
		walk_first   = 1'b1;
		walk_stopped = 1'b0;
		walk_cand    = 1'b0;
		walk_exp     = '0;
		walk_mant    = '0;
		walk_matched = 1'b0;
	endtask

	// Advance the REMB walk by one byte; on the last byte queue the report.
	task automatic remb_walk_byte(input logic [7:0] b, input logic last);
		logic            held;
		int unsigned     nxt;
		logic [63:0]     wide;
		bitrate_report_t r;
		held = walk_stopped || walk_matched;
		if (!held) begin
			case (walk_pos)
				POS_HDR: begin
					if (walk_first && b[7:6] != RTCP_VERSION) begin
						walk_stopped = 1'b1;
						held = 1'b1;
					end else begin
						walk_cand = (b[4:0] == FMT_REMB);
					end
				end
				POS_TYPE:   walk_cand = walk_cand && (b == TYPE_PSFB);
				POS_LEN_HI: walk_words = {b, 8'h00};
				POS_LEN_LO: begin
					walk_words = {walk_words[15:8], b};
					if (walk_words < MIN_REMB_WORDS)
						walk_cand = 1'b0;
					if (walk_words == '0) begin
						walk_stopped = 1'b1;
						held = 1'b1;
					end
				end
				POS_ID0: walk_cand = walk_cand && (b == CHAR_R);
				POS_ID1: walk_cand = walk_cand && (b == CHAR_E);
				POS_ID2: walk_cand = walk_cand && (b == CHAR_M);
				POS_ID3: walk_cand = walk_cand && (b == CHAR_B);
				POS_BR0: begin
					walk_exp  = b[7:2];
					walk_mant = {b[1:0], 16'h0000};
				end
				POS_BR1: walk_mant = walk_mant | {2'b00, b, 8'h00};
				POS_BR2: begin
					walk_mant = walk_mant | {10'h000, b};
					if (walk_cand) begin
						walk_matched = 1'b1;
						held = 1'b1;
					end
				end
				default: ;
			endcase
		end
		if (!held) begin
			nxt = int'(walk_pos) + 1;
			if (walk_pos >= POS_LEN_LO && nxt == (int'(walk_words) + 1) * 4) begin
				walk_pos   = '0;
				walk_first = 1'b0;
				walk_cand  = 1'b0;
			end else begin
				walk_pos = nxt[POS_W-1:0];
			end
		end
		if (last) begin
			r.found = walk_matched;
			r.rate  = '0;
			r.ovf   = 1'b0;
			if (walk_matched && walk_mant != '0) begin
				if (walk_exp >= 6'd32) begin
					r.ovf = 1'b1;
				end else begin
					wide = {46'd0, walk_mant} << walk_exp;
					if (wide[63:32] != '0)
						r.ovf = 1'b1;
					else
						r.rate = wide[31:0];
				end
				if (r.ovf)
					r.rate = '1;
			end
			bitrate_reports_q.push_back(r);
			walk_clear();
		end
	endtask

	task automatic put(input int unsigned idx, input logic [7:0] v);
		if (idx < pkt.size())
			pkt[idx] = v;
	endtask

	// Append one sub-packet, cut to at most cap bytes.
	task automatic append_sub(input logic remb, input logic [WORDS_W-1:0] words,
	                          input logic [EXP_W-1:0] ex, input logic [MANT_W-1:0] mt,
	                          input int unsigned cap);
		int unsigned base;
		int unsigned n;
		base = pkt.size();
		n = (int'(words) + 1) * 4;
		if (n > cap)
			n = cap;
		repeat (n) pkt.push_back(8'($urandom));
		if (remb) begin
			put(base, {RTCP_VERSION, 1'($urandom), FMT_REMB});
			put(base + 1, TYPE_PSFB);
			put(base + 12, CHAR_R);
			put(base + 13, CHAR_E);
			put(base + 14, CHAR_M);
			put(base + 15, CHAR_B);
			put(base + 17, {ex, mt[17:16]});
			put(base + 18, mt[15:8]);
			put(base + 19, mt[7:0]);
		end else if ($urandom_range(0, 3) == 0) begin
			put(base + 1, TYPE_PSFB);
		end
		put(base + 2, words[15:8]);
		put(base + 3, words[7:0]);
	endtask

	task automatic send_packet(input logic drain);
		byte_item_t it;
		foreach (pkt[i]) begin
			it.data  = pkt[i];
			it.last  = (i == pkt.size() - 1);
			it.drain = drain && (i == 0);
			tx_bytes_q.push_back(it);
		end
		pkt.delete();
	endtask

	function automatic logic [EXP_W-1:0] pick_exp();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return '1;
			2:       return EXP_W'($urandom_range(13, 16));
			default: return EXP_W'($urandom);
		endcase
	endfunction

	function automatic logic [MANT_W-1:0] pick_mant();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return '1;
			2:       return MANT_W'(1);
			default: return MANT_W'($urandom);
		endcase
	endfunction

	task automatic build_compound();
		int unsigned nsub;
		int unsigned at;
		nsub = $urandom_range(1, 4);
		at   = $urandom_range(0, nsub);
		for (int unsigned i = 0; i < nsub; i++) begin
			if (i == at)
				append_sub(1'b1, ($urandom_range(0, 5) == 0) ? WORDS_W'($urandom_range(1, 3))
				           : WORDS_W'($urandom_range(4, 7)), pick_exp(), pick_mant(), NO_CAP);
			else if ($urandom_range(0, 3) == 0)
				append_sub(1'b1, WORDS_W'($urandom_range(4, 6)), pick_exp(), pick_mant(), NO_CAP);
			else
				append_sub(1'b0, WORDS_W'($urandom_range(1, 5)), '0, '0, NO_CAP);
		end
		pkt[0][7:6] = RTCP_VERSION;
	endtask

	task automatic build_random_packet();
		int unsigned keep;
		int unsigned idx;
		case ($urandom_range(0, 11))
			7: repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
			8: begin
				build_compound();
				case ($urandom_range(0, 2))
					0:       pkt[0][7:6] = 2'd0;
					1:       pkt[0][7:6] = 2'd1;
					default: pkt[0][7:6] = 2'd3;
				endcase
			end
			9: begin
				if ($urandom_range(0, 1) == 0)
					append_sub(1'b0, WORDS_W'($urandom_range(1, 3)), '0, '0, NO_CAP);
				append_sub(1'($urandom), '0, '0, '0, NO_CAP);
				append_sub(1'b1, WORDS_W'(4), pick_exp(), pick_mant(), NO_CAP);
				pkt[0][7:6] = RTCP_VERSION;
			end
			10: begin
				// long declared length, packet cut to between 4 and 40 bytes
				append_sub(1'($urandom), ($urandom_range(0, 2) == 0) ? WORDS_W'('1)
				           : WORDS_W'($urandom_range(16'h0008, 16'hFFFF)),
				           pick_exp(), pick_mant(), $urandom_range(4, 40));
				pkt[0][7:6] = RTCP_VERSION;
			end
			11: pkt.push_back(8'($urandom));
			default: begin
				build_compound();
				if ($urandom_range(0, 7) == 0) begin
					idx = $urandom_range(0, pkt.size() - 1);
					pkt[idx][$urandom_range(0, 7)] ^= 1'b1;
				end
				if ($urandom_range(0, 5) == 0) begin
					keep = $urandom_range(1, pkt.size());
					while (pkt.size() > keep)
						void'(pkt.pop_back());
				end
			end
		endcase
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** rtcp_remb_bitrate_extract: FAILED **");
			$finish;
		end
	end

	// Check results first, then predict from the byte taken at this edge.
	always @(posedge clk) begin : monitor
		bitrate_report_t want;
		in_took = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (bitrate_reports_q.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("ERROR @%0t: unexpected result found=%b rate=%h ovf=%b",
						         $realtime, remb_found, bitrate_value, bitrate_overflow);
				end else begin
					want = bitrate_reports_q.pop_front();
					if (remb_found !== want.found || bitrate_value !== want.rate ||
					    bitrate_overflow !== want.ovf) begin
						err_count++;
						if (err_count <= 10)
							$display("ERROR @%0t: exp found=%b rate=%h ovf=%b, got found=%b rate=%h ovf=%b",
							         $realtime, want.found, want.rate, want.ovf,
							         remb_found, bitrate_value, bitrate_overflow);
					end
				end
			end
			if (in_valid && !in_stall) begin
				in_took = 1'b1;
				taken_bytes++;
				remb_walk_byte(data_byte, last_byte);
			end
		end
		idle_ok = (taken_bytes + CALM_TAIL < total_bytes) && (taken_bytes % 400 < 300);
	end

	always @(negedge clk) begin : driver
		logic nv;
		if (arst_n) begin
			if (in_took)
				void'(tx_bytes_q.pop_front());
			if (!in_valid || in_took) begin
				nv = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (tx_bytes_q.size() != 0 &&
				             !(tx_bytes_q[0].drain && bitrate_reports_q.size() != 0)) begin
					if (idle_ok && $urandom_range(0, 7) == 0) begin
						gap_left = $urandom_range(0, 18);
					end else begin
						nv = 1'b1;
						data_byte <= tx_bytes_q[0].data;
						last_byte <= tx_bytes_q[0].last;
					end
				end
				in_valid <= nv;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (!hold_done && taken_bytes >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_ok && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 18);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic drain_marked;
		drain_marked = 1'b0;
		walk_clear();

		// one-byte packet with a bad version
		pkt.push_back(8'h00);
		send_packet(1'b0);
		// REMB header that declares zero length
		pkt = '{{RTCP_VERSION, 1'b0, FMT_REMB}, TYPE_PSFB, 8'h00, 8'h00};
		send_packet(1'b0);
		// smallest REMB, largest exponent and mantissa: saturates
		append_sub(1'b1, MIN_REMB_WORDS, '1, '1, 20);
		send_packet(1'b0);

		while (tx_bytes_q.size() < RANDOM_BYTES + 25) begin
			build_random_packet();
			if (!drain_marked && tx_bytes_q.size() >= DRAIN_AT) begin
				drain_marked = 1'b1;
				send_packet(1'b1);
			end else begin
				send_packet(1'b0);
			end
		end
		total_bytes = tx_bytes_q.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (tx_bytes_q.size() != 0 || bitrate_reports_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (err_count == 0 && bitrate_reports_q.size() == 0)
			$display("** rtcp_remb_bitrate_extract: PASSED **");
		else
			$display("** rtcp_remb_bitrate_extract: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
hdl/rrbe_pkg.sv
hdl/rrbe_walk.sv
hdl/rrbe_scale.sv
hdl/rtcp_remb_bitrate_extract.sv
tb/sv/rtcp_remb_bitrate_extract_tb.sv
